// ===== sv/gdda_pkg.sv =====
// Package for the DDA grid column raycaster.
// Holds the channel payload structs, register indexes, constants and the sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gdda_pkg;

    // Cast/write command payload
    typedef struct packed {
        logic       operation;
        logic [9:0] column;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [7:0] cell_value;
    } gdda_cmd_t;

    // Result payload
    typedef struct packed {
        logic        hit_found;
        logic [5:0]  hit_cell_x;
        logic [5:0]  hit_cell_y;
        logic        hit_side;
        logic [23:0] wall_distance;
        logic [9:0]  stripe_top;
        logic [9:0]  stripe_bottom;
    } gdda_res_t;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;

    // Register reset values
    localparam logic [21:0] POS_X_RST   = 22'd2097152;
    localparam logic [21:0] POS_Y_RST   = 22'd2097152;
    localparam logic [15:0] DIR_X_RST   = 16'hC000;
    localparam logic [15:0] DIR_Y_RST   = 16'h0000;
    localparam logic [15:0] PLANE_X_RST = 16'h0000;
    localparam logic [15:0] PLANE_Y_RST = 16'd10813;

    localparam logic [7:0]  WALL_BASE = 8'd48;
    localparam logic [23:0] DIST_SAT  = 24'hFFFFFF;
    localparam logic [31:0] RECIP_NUM = 32'h4000_0000;
    localparam logic [15:0] CAM_BIAS  = 16'h4000;
    localparam logic [16:0] FRAC_ONE  = 17'h10000;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM,
        ST_RAY_X,
        ST_RAY_Y,
        ST_DELTA_X,
        ST_DELTA_X_WAIT,
        ST_DELTA_Y_WAIT,
        ST_SIDE_X,
        ST_SIDE_Y,
        ST_START,
        ST_STEP,
        ST_READ,
        ST_TEST,
        ST_LINE,
        ST_LINE_WAIT,
        ST_RESULT
    } gdda_state_t;

endpackage

`default_nettype wire

// ===== sv/grid_dda_column_raycaster.sv =====
// A cast runs the camera, ray, delta and side-distance states, then DDA steps (step, map read,
// test), at most 4 x MAP_SIZE + 4 of them; a miss skips the line-height division.
// The block takes one item at a time: a map write is done while idle, the next item is taken once a
// cast's result is loaded to the output. Reset (rst_n, async, active low) loads defaults, then
// a pass over all (MAP_SIZE rounded up to a power of two)^2 cells (4096 by default) clears the map.
// Depends on gdda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grid_dda_column_raycaster
    import gdda_pkg::*;
#(
    parameter int MAP_SIZE      = 64,
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire gdda_cmd_t   cmd,
    output logic             res_valid,
    input  wire logic        res_stall,
    output gdda_res_t        res,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [21:0] cfg_data
);

    localparam int MW       = $clog2(MAP_SIZE);
    localparam int CW       = ((MW > 6) ? MW : 6) + 2;
    localparam int AW       = 2 * MW;
    localparam int DEPTH    = 1 << AW;
    localparam int STEP_MAX = 4 * MAP_SIZE + 4;
    localparam int SCW      = $clog2(STEP_MAX + 1);
    localparam int SDW      = 25 + SCW;
    localparam int LW       = $clog2(2 * SCREEN_HEIGHT + 1);
    localparam int RW       = LW + 2;

    localparam logic [12:0]          SW13     = 13'(SCREEN_WIDTH);
    localparam logic [31:0]          LINE_NUM = 32'(SCREEN_HEIGHT) << 16;
    localparam logic [LW-1:0]        LINE_MAX = LW'(2 * SCREEN_HEIGHT);
    localparam logic signed [CW-1:0] MAP_S    = CW'(MAP_SIZE);
    localparam logic [SCW-1:0]       STEP_LIM = SCW'(STEP_MAX);
    localparam logic signed [RW-1:0] H_HALF   = RW'(SCREEN_HEIGHT / 2);
    localparam logic signed [RW-1:0] H_LAST   = RW'(SCREEN_HEIGHT - 1);
    // ceil(2^39 / SCREEN_WIDTH): (col * CAM_MUL) >> 24 is exactly floor(col * 2^15 / width)
    // because col * SCREEN_WIDTH never exceeds 2^24
    localparam logic [35:0]          CAM_MUL  =
        36'(((64'd1 << 39) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    // Wall map, one bit per cell
    logic map_mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          rd_reg;

    gdda_state_t state_reg, state_next;

    // Configuration registers
    logic [21:0] pos_x_reg, pos_y_reg;
    logic [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    // Cast working registers
    logic [12:0]          col_reg, col_next;
    logic [15:0]          cam_reg, cam_next;
    logic [17:0]          ray_x_reg, ray_x_next, ray_y_reg, ray_y_next;
    logic [23:0]          dx_reg, dx_next, dy_reg, dy_next;
    logic [SDW-1:0]       sdx_reg, sdx_next, sdy_reg, sdy_next, perp_reg, perp_next;
    logic signed [CW-1:0] mx_reg, mx_next, my_reg, my_next;
    logic                 side_reg, side_next, hit_reg, hit_next;
    logic [SCW-1:0]       step_reg, step_next;
    logic [23:0]          dist_reg, dist_next;
    logic [LW-1:0]        line_reg, line_next;
    logic [AW-1:0]        clr_reg, clr_next;

    // Shared multiplier
    logic signed [17:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [42:0] prod_reg;

    // Camera coordinate by constant reciprocal
    logic [48:0] cam_prod;

    // Shared restoring divider, one quotient bit per cycle
    logic        div_start;
    logic [31:0] div_num;
    logic [23:0] div_den;
    logic [31:0] quo_reg, quo_next;
    logic [23:0] rem_reg, rem_next, den_reg, den_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic [24:0] trial;
    logic        trial_ge;
    logic        div_done;

    // Output register
    gdda_res_t res_reg, res_next;
    logic      res_valid_reg, res_valid_next;

    // Helpers
    logic [17:0]          mag_x, mag_y;
    logic [16:0]          frac_x, frac_y;
    logic [23:0]          quo_sat;
    logic signed [CW-1:0] mx_step, my_step;
    logic                 take_x, leave_map, start_out;
    logic [CW-1:0]        wcx, wcy;
    logic signed [RW-1:0] half, ds, de;

    assign cfg_ready = 1'b1;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign mag_x   = ray_x_reg[17] ? 18'(-ray_x_reg) : ray_x_reg;
    assign mag_y   = ray_y_reg[17] ? 18'(-ray_y_reg) : ray_y_reg;
    assign frac_x  = ray_x_reg[17] ? {1'b0, pos_x_reg[15:0]} : FRAC_ONE - {1'b0, pos_x_reg[15:0]};
    assign frac_y  = ray_y_reg[17] ? {1'b0, pos_y_reg[15:0]} : FRAC_ONE - {1'b0, pos_y_reg[15:0]};
    assign quo_sat = (quo_reg[31:24] != 8'd0) ? DIST_SAT : quo_reg[23:0];
    assign mx_step = ray_x_reg[17] ? mx_reg - CW'(1) : mx_reg + CW'(1);
    assign my_step = ray_y_reg[17] ? my_reg - CW'(1) : my_reg + CW'(1);
    assign take_x  = (sdx_reg < sdy_reg);
    assign start_out = (mx_reg >= MAP_S) || (my_reg >= MAP_S);
    assign wcx = CW'(cmd.cell_x);
    assign wcy = CW'(cmd.cell_y);
    assign cam_prod = {36'd0, col_reg} * {13'd0, CAM_MUL};

    // Divider datapath
    assign trial    = {rem_reg, quo_reg[31]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign div_done = (dcnt_reg == 6'd0);

    always_comb
    begin
        if (div_start)
        begin
            quo_next  = div_num;
            rem_next  = 24'd0;
            den_next  = div_den;
            dcnt_next = 6'd32;
        end
        else if (!div_done)
        begin
            quo_next  = {quo_reg[30:0], trial_ge};
            rem_next  = trial_ge ? 24'(trial - {1'b0, den_reg}) : trial[23:0];
            den_next  = den_reg;
            dcnt_next = dcnt_reg - 6'd1;
        end
        else
        begin
            quo_next  = quo_reg;
            rem_next  = rem_reg;
            den_next  = den_reg;
            dcnt_next = dcnt_reg;
        end
    end

    // Stripe rows from line height
    assign half = RW'(line_reg >> 1);
    assign ds   = H_HALF - half;
    assign de   = H_HALF + half;

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        cam_next       = cam_reg;
        ray_x_next     = ray_x_reg;
        ray_y_next     = ray_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sdx_next       = sdx_reg;
        sdy_next       = sdy_reg;
        perp_next      = perp_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        side_next      = side_reg;
        hit_next       = hit_reg;
        step_next      = step_reg;
        dist_next      = dist_reg;
        line_next      = line_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        mem_we         = 1'b0;
        mem_waddr      = clr_reg;
        mem_wdata      = 1'b0;
        div_start      = 1'b0;
        div_num        = RECIP_NUM;
        div_den        = 24'd0;
        mul_a          = $signed(plane_x_reg);
        mul_b          = $signed(cam_reg);
        leave_map      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.operation == OP_WRITE)
                    begin
                        mem_waddr = {wcx[MW-1:0], wcy[MW-1:0]};
                        mem_wdata = (cmd.cell_value > WALL_BASE);
                        mem_we    = (wcx < CW'(MAP_SIZE)) && (wcy < CW'(MAP_SIZE));
                    end
                    else
                    begin
                        col_next   = ({3'd0, cmd.column} >= SW13) ? SW13 - 13'd1
                                                                 : {3'd0, cmd.column};
                        state_next = ST_CAM;
                    end
                end
            end
            ST_CAM:
            begin
                cam_next   = cam_prod[39:24] - CAM_BIAS;
                state_next = ST_RAY_X;
            end
            ST_RAY_X:
            begin
                state_next = ST_RAY_Y;
            end
            ST_RAY_Y:
            begin
                mul_a      = $signed(plane_y_reg);
                ray_x_next = {{2{dir_x_reg[15]}}, dir_x_reg} + prod_reg[31:14];
                state_next = ST_DELTA_X;
            end
            ST_DELTA_X:
            begin
                ray_y_next = {{2{dir_y_reg[15]}}, dir_y_reg} + prod_reg[31:14];
                div_start  = 1'b1;
                div_den    = {6'd0, mag_x};
                state_next = ST_DELTA_X_WAIT;
            end
            ST_DELTA_X_WAIT:
            begin
                if (div_done)
                begin
                    dx_next    = (ray_x_reg == 18'd0) ? DIST_SAT : quo_sat;
                    div_start  = 1'b1;
                    div_den    = {6'd0, mag_y};
                    state_next = ST_DELTA_Y_WAIT;
                end
            end
            ST_DELTA_Y_WAIT:
            begin
                if (div_done)
                begin
                    dy_next    = (ray_y_reg == 18'd0) ? DIST_SAT : quo_sat;
                    state_next = ST_SIDE_X;
                end
            end
            ST_SIDE_X:
            begin
                mul_a      = $signed({1'b0, frac_x});
                mul_b      = $signed({1'b0, dx_reg});
                state_next = ST_SIDE_Y;
            end
            ST_SIDE_Y:
            begin
                mul_a      = $signed({1'b0, frac_y});
                mul_b      = $signed({1'b0, dy_reg});
                sdx_next   = SDW'(prod_reg[40:16]);
                mx_next    = CW'(pos_x_reg[21:16]);
                my_next    = CW'(pos_y_reg[21:16]);
                state_next = ST_START;
            end
            ST_START:
            begin
                sdy_next   = SDW'(prod_reg[40:16]);
                step_next  = '0;
                hit_next   = 1'b0;
                state_next = start_out ? ST_RESULT : ST_STEP;
            end
            ST_STEP:
            begin
                if (step_reg == STEP_LIM)
                    state_next = ST_RESULT;
                else
                begin
                    step_next = step_reg + SCW'(1);
                    if (take_x)
                    begin
                        perp_next = sdx_reg;
                        sdx_next  = sdx_reg + SDW'(dx_reg);
                        mx_next   = mx_step;
                        side_next = 1'b0;
                        leave_map = (mx_step < 0) || (mx_step >= MAP_S);
                    end
                    else
                    begin
                        perp_next = sdy_reg;
                        sdy_next  = sdy_reg + SDW'(dy_reg);
                        my_next   = my_step;
                        side_next = 1'b1;
                        leave_map = (my_step < 0) || (my_step >= MAP_S);
                    end
                    state_next = leave_map ? ST_RESULT : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (rd_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_LINE;
                end
                else
                    state_next = ST_STEP;
            end
            ST_LINE:
            begin
                dist_next = (perp_reg > SDW'(DIST_SAT)) ? DIST_SAT : perp_reg[23:0];
                if (dist_next == 24'd0)
                begin
                    line_next  = LINE_MAX;
                    state_next = ST_RESULT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = LINE_NUM;
                    div_den    = dist_next;
                    state_next = ST_LINE_WAIT;
                end
            end
            ST_LINE_WAIT:
            begin
                if (div_done)
                begin
                    line_next  = (quo_reg > 32'(LINE_MAX)) ? LINE_MAX : LW'(quo_reg);
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    if (hit_reg)
                    begin
                        res_next.hit_found     = 1'b1;
                        res_next.hit_cell_x    = mx_reg[5:0];
                        res_next.hit_cell_y    = my_reg[5:0];
                        res_next.hit_side      = side_reg;
                        res_next.wall_distance = dist_reg;
                        res_next.stripe_top    = (ds < 0) ? 10'd0 : ds[9:0];
                        res_next.stripe_bottom = (de > H_LAST) ? H_LAST[9:0] : de[9:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Map storage: write port and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        rd_reg <= map_mem[{mx_reg[MW-1:0], my_reg[MW-1:0]}];
    end

    // Shared multiplier product register
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            dcnt_reg      <= 6'd0;
            pos_x_reg     <= POS_X_RST;
            pos_y_reg     <= POS_Y_RST;
            dir_x_reg     <= DIR_X_RST;
            dir_y_reg     <= DIR_Y_RST;
            plane_x_reg   <= PLANE_X_RST;
            plane_y_reg   <= PLANE_Y_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            dcnt_reg      <= dcnt_next;
            // Configuration transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POS_X:   pos_x_reg   <= cfg_data;
                    REG_POS_Y:   pos_y_reg   <= cfg_data;
                    REG_DIR_X:   dir_x_reg   <= cfg_data[15:0];
                    REG_DIR_Y:   dir_y_reg   <= cfg_data[15:0];
                    REG_PLANE_X: plane_x_reg <= cfg_data[15:0];
                    REG_PLANE_Y: plane_y_reg <= cfg_data[15:0];
                    default:     ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        cam_reg   <= cam_next;
        ray_x_reg <= ray_x_next;
        ray_y_reg <= ray_y_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sdx_reg   <= sdx_next;
        sdy_reg   <= sdy_next;
        perp_reg  <= perp_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        side_reg  <= side_next;
        hit_reg   <= hit_next;
        step_reg  <= step_next;
        dist_reg  <= dist_next;
        line_reg  <= line_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

// ===== sv/gdda_checker.sv =====
// Port-level checker for the DDA grid column raycaster, bound to the top level.
// Depends on gdda_pkg and grid_dda_column_raycaster.
`timescale 1ns / 1ps
`default_nettype none

module gdda_checker
    import gdda_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_stall,
    input wire gdda_cmd_t cmd,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire gdda_res_t res
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // A cast transfer makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.operation == OP_CAST) |=> cmd_stall)
        else $error("cast transfer did not start work");

    // A map write on an empty output produces no result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.operation == OP_WRITE) && !res_valid |=> !res_valid)
        else $error("map write produced a result");

    // A missed ray reports all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit_found |-> (res.wall_distance == 24'd0)
            && (res.stripe_top == 10'd0) && (res.stripe_bottom == 10'd0)
            && (res.hit_cell_x == 6'd0) && (res.hit_cell_y == 6'd0) && !res.hit_side)
        else $error("miss result carries nonzero fields");

endmodule

bind grid_dda_column_raycaster gdda_checker u_gdda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire
